// File: design/ts_descriptor_loop_parser_core_assert.svh
// Assertion macros for the descriptor loop parser core.
// Expects clk and rst_n in the scope of each use.
`ifndef TS_DESCRIPTOR_LOOP_PARSER_CORE_ASSERT_SVH
`define TS_DESCRIPTOR_LOOP_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TSDLP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TSDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tsdlp_pkg.sv
// Shared types, constants and helpers of the descriptor loop parser.
// No dependencies.
package tsdlp_pkg;

  localparam int MAX_LOOP_BYTES_DEF = 65535;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COUNT_W    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ENABLE = 2'd1;

  localparam logic [7:0] TAG_CA        = 8'h09;
  localparam logic [7:0] TAG_SERVICE   = 8'h48;
  localparam logic [7:0] TAG_STREAM_ID = 8'h52;
  localparam logic [7:0] CA_FIXED_MASK = 8'hE0;

  localparam logic [7:0] CA_MIN_LEN    = 8'd4;
  localparam logic [7:0] SVC_MIN_LEN   = 8'd3;
  localparam logic [7:0] STREAM_ID_LEN = 8'd1;

  localparam logic [7:0] IDX_SYS_HI = 8'd0;
  localparam logic [7:0] IDX_SYS_LO = 8'd1;
  localparam logic [7:0] IDX_PID_HI = 8'd2;
  localparam logic [7:0] IDX_PID_LO = 8'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RK_ACCEPT   = 2'd0,
    RK_REJECT   = 2'd1,
    RK_TRUNC    = 2'd2,
    RK_END_STOP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    KT_OTHER     = 2'd0,
    KT_CA        = 2'd1,
    KT_SERVICE   = 2'd2,
    KT_STREAM_ID = 2'd3
  } known_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_last;
  } item_t;

  typedef struct packed {
    logic [7:0] target_tag;
    logic       target_enable;
  } cfg_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [7:0]         descr_tag;
    logic [7:0]         desc_length;
    known_t             known_type;
    logic [15:0]        ca_system_id;
    logic [12:0]        ca_pid;
    logic [7:0]         service_type;
    logic [7:0]         component_tag;
    logic [COUNT_W-1:0] accepted_count;
    logic               first_match_res;
    logic               block_done;
  } result_t;

  function automatic known_t kind_of(input logic [7:0] tag);
    known_t k;
    if (tag == TAG_CA) begin
      k = KT_CA;
    end else if (tag == TAG_SERVICE) begin
      k = KT_SERVICE;
    end else if (tag == TAG_STREAM_ID) begin
      k = KT_STREAM_ID;
    end else begin
      k = KT_OTHER;
    end
    return k;
  endfunction

endpackage

// File: design/tsdlp_in_stage.sv
// Input register of the descriptor loop parser: holds one item for the parser.
// Depends on tsdlp_pkg.
module tsdlp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsdlp_pkg::item_t in_item,
  input  logic            take,
  output logic            s_valid,
  output tsdlp_pkg::item_t s_item
);
  import tsdlp_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

// File: design/tsdlp_parser.sv
// Parse state and per-byte step logic of the descriptor loop parser.
// Depends on tsdlp_pkg.
module tsdlp_parser #(
  parameter int MAX_LOOP_BYTES = tsdlp_pkg::MAX_LOOP_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  tsdlp_pkg::item_t   item,
  input  tsdlp_pkg::cfg_t    cfg,
  output logic               res_have,
  output tsdlp_pkg::result_t res
);
  import tsdlp_pkg::*;

  localparam int CNT_W = $clog2(MAX_LOOP_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LOOP_BYTES - 1);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   loop_cnt_r, loop_cnt_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               match_seen_r, match_seen_nxt;

  logic [7:0]  cur_tag_r, cur_tag_nxt;
  logic [7:0]  cur_length_r, cur_length_nxt;
  logic [7:0]  pay_idx_r, pay_idx_nxt;
  logic [15:0] word_a_r, word_a_nxt;
  logic [12:0] word_b_r, word_b_nxt;
  logic        fixed_ok_r, fixed_ok_nxt;

  logic [7:0]         b;
  logic               last_eff;
  logic [7:0]         idx_inc;
  logic [7:0]         fin_len;
  logic               fin;
  logic               ok;
  logic               accept;
  known_t             kt;
  logic [15:0]        word_a_upd;
  logic [12:0]        word_b_upd;
  logic               fixed_upd;
  logic [COUNT_W-1:0] count_inc;
  logic               match;
  logic [7:0]         trunc_tag;

  always_comb begin
    b        = item.data_byte;
    last_eff = item.block_last || (loop_cnt_r >= CNT_LAST);
    idx_inc  = pay_idx_r + 8'd1;
    fin_len  = (phase_r == PH_LEN) ? b : cur_length_r;
    fin      = ((phase_r == PH_LEN) && (b == 8'd0)) ||
               ((phase_r == PH_PAY) && (idx_inc == cur_length_r));

    word_a_upd = word_a_r;
    word_b_upd = word_b_r;
    fixed_upd  = fixed_ok_r;
    if (phase_r == PH_PAY) begin
      unique case (pay_idx_r)
        IDX_SYS_HI: word_a_upd = {b, 8'h00};
        IDX_SYS_LO: word_a_upd = {word_a_r[15:8], b};
        IDX_PID_HI: begin
          word_b_upd = {b[4:0], 8'h00};
          fixed_upd  = ((b & CA_FIXED_MASK) == CA_FIXED_MASK);
        end
        IDX_PID_LO: word_b_upd = {word_b_r[12:8], b};
        default: ;
      endcase
    end

    kt = kind_of(cur_tag_r);
    unique case (kt)
      KT_CA:        ok = (fin_len >= CA_MIN_LEN) && fixed_upd;
      KT_SERVICE:   ok = (fin_len >= SVC_MIN_LEN);
      KT_STREAM_ID: ok = (fin_len == STREAM_ID_LEN);
      default:      ok = 1'b1;
    endcase

    accept    = fin && ok;
    count_inc = (accept && (count_r != COUNT_MAX)) ? count_r + COUNT_W'(1) : count_r;
    match     = accept && cfg.target_enable && !match_seen_r &&
                (cur_tag_r == cfg.target_tag);
    res_have  = fin || last_eff;
    trunc_tag = (phase_r == PH_TAG) ? b : cur_tag_r;
  end

  // result of this byte
  always_comb begin
    res                 = '0;
    res.accepted_count  = count_inc;
    res.first_match_res = match;
    res.block_done      = last_eff;
    if (fin) begin
      res.result_kind = ok ? RK_ACCEPT : RK_REJECT;
      res.descr_tag   = cur_tag_r;
      res.desc_length = fin_len;
      res.known_type  = kt;
      if (ok) begin
        unique case (kt)
          KT_CA: begin
            res.ca_system_id = word_a_upd;
            res.ca_pid       = word_b_upd;
          end
          KT_SERVICE:   res.service_type  = word_a_upd[15:8];
          KT_STREAM_ID: res.component_tag = word_a_upd[15:8];
          default: ;
        endcase
      end
    end else if (phase_r == PH_STOP) begin
      res.result_kind = RK_END_STOP;
    end else begin
      res.result_kind = RK_TRUNC;
      res.descr_tag   = trunc_tag;
      res.known_type  = kind_of(trunc_tag);
      unique case (phase_r)
        PH_PAY:  res.desc_length = cur_length_r;
        PH_LEN:  res.desc_length = b;
        default: res.desc_length = 8'd0;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (last_eff) begin
      phase_nxt = PH_TAG;
    end else begin
      unique case (phase_r)
        PH_TAG: phase_nxt = PH_LEN;
        PH_LEN: begin
          if (fin) begin
            phase_nxt = ok ? PH_TAG : PH_STOP;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          if (fin) begin
            phase_nxt = ok ? PH_TAG : PH_STOP;
          end
        end
        PH_STOP: phase_nxt = PH_STOP;
        default: phase_nxt = PH_TAG;
      endcase
    end
  end

  // next counters and fields
  always_comb begin
    loop_cnt_nxt   = loop_cnt_r + CNT_W'(1);
    count_nxt      = count_inc;
    match_seen_nxt = match_seen_r || match;
    cur_tag_nxt    = cur_tag_r;
    cur_length_nxt = cur_length_r;
    pay_idx_nxt    = pay_idx_r;
    word_a_nxt     = word_a_r;
    word_b_nxt     = word_b_r;
    fixed_ok_nxt   = fixed_ok_r;
    unique case (phase_r)
      PH_TAG: begin
        cur_tag_nxt    = b;
        cur_length_nxt = 8'd0;
        pay_idx_nxt    = 8'd0;
        word_a_nxt     = '0;
        word_b_nxt     = '0;
        fixed_ok_nxt   = 1'b0;
      end
      PH_LEN: cur_length_nxt = b;
      PH_PAY: begin
        pay_idx_nxt  = idx_inc;
        word_a_nxt   = word_a_upd;
        word_b_nxt   = word_b_upd;
        fixed_ok_nxt = fixed_upd;
      end
      default: ;
    endcase
    if (last_eff) begin
      loop_cnt_nxt   = '0;
      count_nxt      = '0;
      match_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG;
      loop_cnt_r   <= '0;
      count_r      <= '0;
      match_seen_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      loop_cnt_r   <= loop_cnt_nxt;
      count_r      <= count_nxt;
      match_seen_r <= match_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      cur_tag_r    <= cur_tag_nxt;
      cur_length_r <= cur_length_nxt;
      pay_idx_r    <= pay_idx_nxt;
      word_a_r     <= word_a_nxt;
      word_b_r     <= word_b_nxt;
      fixed_ok_r   <= fixed_ok_nxt;
    end
  end

endmodule

// File: design/tsdlp_out_stage.sv
// Result register of the descriptor loop parser: holds one result item.
// Depends on tsdlp_pkg.
module tsdlp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  tsdlp_pkg::result_t res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output tsdlp_pkg::result_t out_res
);
  import tsdlp_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: design/ts_descriptor_loop_parser_core.sv
// Top level of the descriptor loop parser: input register, parser, result register.
// Depends on tsdlp_pkg, tsdlp_in_stage, tsdlp_parser, tsdlp_out_stage and the assert header.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_data_byte, in_block_last
//   out      out_valid/out_ready  out_result_kind .. out_block_done
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while the result register can take its result; each byte is held
// in the input register until parsed, and its result, if any, is then loaded into the result register.
// A byte that gives no result retires even while the result register is stalled.
// Synchronous active-low reset clears all control state; no clearing pass.
// cfg_ready is always high.
`include "ts_descriptor_loop_parser_core_assert.svh"

module ts_descriptor_loop_parser_core #(
  parameter int MAX_LOOP_BYTES = tsdlp_pkg::MAX_LOOP_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_block_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_result_kind,
  output logic [7:0]                         out_descr_tag,
  output logic [7:0]                         out_desc_length,
  output logic [1:0]                         out_known_type,
  output logic [15:0]                        out_ca_system_id,
  output logic [12:0]                        out_ca_pid,
  output logic [7:0]                         out_service_type,
  output logic [7:0]                         out_component_tag,
  output logic [tsdlp_pkg::COUNT_W-1:0]      out_accepted_count,
  output logic                               out_first_match_res,
  output logic                               out_block_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tsdlp_pkg::*;

  item_t   in_item;
  item_t   s_item;
  logic    s_valid;
  logic    take;
  logic    load;
  logic    res_have;
  logic    out_free;
  result_t res;
  result_t out_res;
  cfg_t    cfg_r;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.block_last = in_block_last;

  assign take = s_valid && (!res_have || out_free);
  assign load = take && res_have;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_TAG:    cfg_r.target_tag    <= cfg_data[7:0];
        REG_TARGET_ENABLE: cfg_r.target_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tsdlp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  tsdlp_parser #(
    .MAX_LOOP_BYTES (MAX_LOOP_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (take),
    .item     (s_item),
    .cfg      (cfg_r),
    .res_have (res_have),
    .res      (res)
  );

  tsdlp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_result_kind     = out_res.result_kind;
  assign out_descr_tag       = out_res.descr_tag;
  assign out_desc_length     = out_res.desc_length;
  assign out_known_type      = out_res.known_type;
  assign out_ca_system_id    = out_res.ca_system_id;
  assign out_ca_pid          = out_res.ca_pid;
  assign out_service_type    = out_res.service_type;
  assign out_component_tag   = out_res.component_tag;
  assign out_accepted_count  = out_res.accepted_count;
  assign out_first_match_res = out_res.first_match_res;
  assign out_block_done      = out_res.block_done;

  `TSDLP_ASSERT_IMPLIES(a_end_kinds_done,
    out_valid && (out_result_kind == RK_TRUNC || out_result_kind == RK_END_STOP),
    out_block_done, "truncated or end-after-stop item without block_done")

  `TSDLP_ASSERT_IMPLIES(a_fields_only_on_accept,
    out_valid && (out_result_kind != RK_ACCEPT),
    out_ca_system_id == 16'd0 && out_ca_pid == 13'd0 && out_service_type == 8'd0 &&
    out_component_tag == 8'd0 && !out_first_match_res,
    "extracted fields set on an item that was not accepted")

  `TSDLP_ASSERT_IMPLIES(a_known_type_matches_tag,
    out_valid && (out_result_kind == RK_ACCEPT || out_result_kind == RK_REJECT),
    out_known_type == kind_of(out_descr_tag), "known_type disagrees with the tag")

  `TSDLP_ASSERT_NEXT(a_in_stage_holds,
    s_valid && !take, s_valid, "buffered item dropped without being parsed")

endmodule
